// ----- sv/keyframe_track_interpolator_unit_macros.svh -----
// Assertion macros for the keyframe track interpolator.
`ifndef KEYFRAME_TRACK_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_UNIT_MACROS_SVH

// Clocked property with the reset disable.
`define KTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold at a clock edge.
`define KTI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- sv/kti_pkg.sv -----
// Package with types, constants and helpers of the keyframe track interpolator.
`timescale 1ns / 1ps
package kti_pkg;

  localparam int Tracks       = 8;
  localparam int KeysPerTrack = 16;
  localparam int TrackW       = 3;
  localparam int SlotW        = 4;
  localparam int AddrW        = TrackW + SlotW;
  localparam int Depth        = Tracks * KeysPerTrack;
  localparam int MulW         = 34;
  localparam int ProdW        = 2 * MulW;
  localparam int CntW         = 6;

  localparam logic [1:0] CURVE_LINEAR  = 2'd1;
  localparam logic [1:0] CURVE_HERMITE = 2'd2;
  localparam logic       FINISH_HOLD   = 1'b0;

  typedef enum logic [2:0] {
    CMD_LOAD_KEY = 3'd0,
    CMD_LOAD_HDR = 3'd1,
    CMD_RESET    = 3'd2,
    CMD_STEP     = 3'd3,
    CMD_SEEK     = 3'd4
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RST, S_RSTV, S_LAST, S_DUR, S_WALK, S_WCMP, S_END, S_MOD, S_SAVE,
    S_HOLDV, S_KA, S_LIN, S_KB, S_TDIV, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
    S_M7, S_M8, S_M9, S_M10, S_FIN, S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [2:0]         track_sel;
    logic [3:0]         key_slot;
    logic [31:0]        key_time;
    logic signed [31:0] key_level;
    logic signed [31:0] key_gradient;
    logic [1:0]         curve_kind;
    logic [4:0]         keys_in_track;
    logic               finish_kind;
    logic [31:0]        frame_step;
  } item_t;

  typedef struct packed {
    logic [2:0]         out_track;
    logic signed [31:0] out_value;
    logic               out_last;
  } res_t;

  typedef struct packed {
    logic [31:0]        key_time;
    logic signed [31:0] key_level;
    logic signed [31:0] key_gradient;
    logic [1:0]         curve;
  } key_t;

  typedef struct packed {
    logic            start;
    logic [MulW-1:0] rem_init;
    logic [32:0]     dividend;
    logic [MulW-1:0] divisor;
    logic [CntW-1:0] steps;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/kti_key_mem.sv -----
// Key store memory with one write port and one registered read port.
`timescale 1ns / 1ps
module kti_key_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [kti_pkg::AddrW-1:0]  waddr_i,
  input  kti_pkg::key_t              wdata_i,
  input  logic [kti_pkg::AddrW-1:0]  raddr_i,
  output kti_pkg::key_t              rdata_o
);

  kti_pkg::key_t mem_q [kti_pkg::Depth];
  kti_pkg::key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/kti_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module kti_mul (
  input  logic                              clk_i,
  input  logic signed [kti_pkg::MulW-1:0]   a_i,
  input  logic signed [kti_pkg::MulW-1:0]   b_i,
  output logic signed [kti_pkg::ProdW-1:0]  p_o
);

  logic signed [kti_pkg::ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- sv/kti_div.sv -----
// Bit-serial restoring divider shared by the wrap and the Hermite t computation.
`timescale 1ns / 1ps
module kti_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kti_pkg::div_req_t           req_i,
  output logic                        busy_o,
  output logic [15:0]                 quot_o,
  output logic [kti_pkg::MulW-1:0]    rem_o
);

  logic [kti_pkg::CntW-1:0] cnt_q;
  logic [kti_pkg::MulW-1:0] rem_q, dsr_q, rem_sh;
  logic [32:0]              dvd_q;
  logic [15:0]              quot_q;
  logic                     ge;

  assign rem_sh = {rem_q[kti_pkg::MulW-2:0], dvd_q[32]};
  assign ge     = rem_sh >= dsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= req_i.steps;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      dvd_q  <= req_i.dividend;
      dsr_q  <= req_i.divisor;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= ge ? rem_sh - dsr_q : rem_sh;
      dvd_q  <= {dvd_q[31:0], 1'b0};
      quot_q <= {quot_q[14:0], ge};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/keyframe_track_interpolator_unit.sv -----
// Top level of the keyframe track interpolator: sequencer, track state and config port.
//
// Commands enter on item_i when start is high and busy is low. Key and header loads
// give no result. Reset, step and seek give one result per active track, in track
// order, each on res_o for one cycle with res_valid_o high; out_last marks the last
// active track. busy falls in the cycle in which the last result is shown.
// A reset command does per track a key store read and an output.
// A step does per track a read of the last key for the duration, a walk over the keys
// passed, and when a looping track wraps a serial modulo in the shared divider and a
// new walk from key 0, then the evaluation: flat or held, linear, or Hermite plus the
// t divide where needed. The sequencer uses the single key store read port and the
// shared multiplier and divider one step at a time. Seek is a step from frame 0.
// After reset all tracks sit at frame 0 with no header, active_tracks is 0 and the
// block is idle at once; key entries hold nothing until loaded. Results cannot be
// held off by the receiver, so none is ever delayed by it.
// active_tracks sits at byte address 0 of the APB port.
`timescale 1ns / 1ps
`include "keyframe_track_interpolator_unit_macros.svh"
module keyframe_track_interpolator_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  kti_pkg::item_t        item_i,
  output logic                  res_valid_o,
  output kti_pkg::res_t         res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int MW = kti_pkg::MulW;

  kti_pkg::state_e state_q, state_d;
  logic [2:0]   tc_q, tc_d;
  logic         rst_cmd_q, rst_cmd_d, seek_q, seek_d, wrap_q, wrap_d;
  logic [31:0]  step_q, step_d, dur_q, dur_d, ta_q, ta_d;
  logic [32:0]  pos_q, pos_d;
  logic [3:0]   seg_q, seg_d;
  logic signed [31:0] la_q, la_d, ga_q, ga_d, lb_q, lb_d, gb_q, gb_d, val_q, val_d;
  logic signed [MW-1:0] delta_q, delta_d, span_q, span_d, s10_q, s10_d, s11_q, s11_d;
  logic [15:0]  tq_q, tq_d, t2_q, t2_d, t3_q, t3_d;
  logic signed [63:0] acc_q, acc_d;
  logic         valid_q, valid_d;
  kti_pkg::res_t res_q, res_d;
  logic [3:0]   active_q;

  logic [4:0]   key_total_q [kti_pkg::Tracks];
  logic         finish_q    [kti_pkg::Tracks];
  logic [31:0]  position_q  [kti_pkg::Tracks];
  logic [3:0]   segment_q   [kti_pkg::Tracks];

  logic         accept, cfg_we, mem_we, trk_we;
  logic [kti_pkg::AddrW-1:0] raddr;
  kti_pkg::key_t rdata, wkey;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [kti_pkg::ProdW-1:0] prod, prod_sh;
  kti_pkg::div_req_t div_req;
  logic         div_busy;
  logic [15:0]  div_quot;
  logic [MW-1:0] div_rem;
  logic [3:0]   n_act, last;
  logic [4:0]   kc, hdr_k;
  logic         is_last_trk;
  logic signed [MW-1:0] delta_c, span_c;
  logic signed [19:0] t2s, t3s, tqs, h00, h01, h10, h11;
  logic signed [63:0] lin_sum;
  logic [31:0]  base_pos;

  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && !paddr[2];
  assign prdata  = !paddr[2] ? {28'd0, active_q} : 32'd0;
  assign n_act   = (active_q > 4'd8) ? 4'd8 : active_q;
  assign kc      = (key_total_q[tc_q] < 5'd2) ? 5'd2 : key_total_q[tc_q];
  assign last    = 4'(kc - 5'd1);
  assign is_last_trk = ({1'b0, tc_q} + 4'd1) == n_act;
  assign busy    = state_q != kti_pkg::S_IDLE;

  assign mem_we  = accept && (item_i.cmd == kti_pkg::CMD_LOAD_KEY);
  assign wkey    = '{key_time: item_i.key_time, key_level: item_i.key_level,
                     key_gradient: item_i.key_gradient, curve: item_i.curve_kind};
  assign hdr_k   = (item_i.keys_in_track < 5'd2) ? 5'd2 :
                   (item_i.keys_in_track > 5'd16) ? 5'd16 : item_i.keys_in_track;

  assign prod_sh = prod >>> 16;
  assign delta_c = $signed({1'b0, pos_q}) - $signed({2'b00, rdata.key_time});
  assign span_c  = $signed({2'b00, rdata.key_time}) - $signed({2'b00, ta_q});
  assign t2s     = $signed({4'd0, t2_q});
  assign t3s     = $signed({4'd0, t3_q});
  assign tqs     = $signed({4'd0, tq_q});
  assign h00     = 20'sd2 * t3s - 20'sd3 * t2s + 20'sd65536;
  assign h01     = 20'sd3 * t2s - 20'sd2 * t3s;
  assign h10     = t3s - 20'sd2 * t2s + tqs;
  assign h11     = t3s - t2s;
  assign lin_sum = 64'(la_q) + prod_sh[63:0];
  assign base_pos = seek_q ? 32'd0 : position_q[tc_q];

  kti_key_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({item_i.track_sel, item_i.key_slot}),
    .wdata_i (wkey),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  kti_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  kti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kti_pkg::S_IDLE;
      valid_q  <= 1'b0;
      active_q <= '0;
      for (int i = 0; i < kti_pkg::Tracks; i++) begin
        key_total_q[i] <= '0;
        finish_q[i]    <= 1'b0;
        position_q[i]  <= '0;
        segment_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we) begin
        active_q <= pwdata[3:0];
      end
      if (accept && (item_i.cmd == kti_pkg::CMD_LOAD_HDR)) begin
        key_total_q[item_i.track_sel] <= hdr_k;
        finish_q[item_i.track_sel]    <= item_i.finish_kind;
      end
      if (trk_we) begin
        position_q[tc_q] <= (state_q == kti_pkg::S_RST) ? 32'd0 : pos_q[31:0];
        segment_q[tc_q]  <= (state_q == kti_pkg::S_RST) ? 4'd0 : seg_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tc_q <= tc_d; rst_cmd_q <= rst_cmd_d; seek_q <= seek_d; wrap_q <= wrap_d;
    step_q <= step_d; dur_q <= dur_d; ta_q <= ta_d; pos_q <= pos_d; seg_q <= seg_d;
    la_q <= la_d; ga_q <= ga_d; lb_q <= lb_d; gb_q <= gb_d; val_q <= val_d;
    delta_q <= delta_d; span_q <= span_d; s10_q <= s10_d; s11_q <= s11_d;
    tq_q <= tq_d; t2_q <= t2_d; t3_q <= t3_d; acc_q <= acc_d; res_q <= res_d;
  end

  always_comb begin
    state_d = state_q; tc_d = tc_q; rst_cmd_d = rst_cmd_q; seek_d = seek_q;
    wrap_d = wrap_q; step_d = step_q; dur_d = dur_q; ta_d = ta_q; pos_d = pos_q;
    seg_d = seg_q; la_d = la_q; ga_d = ga_q; lb_d = lb_q; gb_d = gb_q; val_d = val_q;
    delta_d = delta_q; span_d = span_q; s10_d = s10_q; s11_d = s11_q; tq_d = tq_q;
    t2_d = t2_q; t3_d = t3_q; acc_d = acc_q; res_d = res_q;
    valid_d = 1'b0;
    trk_we  = 1'b0;
    raddr   = {tc_q, seg_q};
    mul_a   = '0;
    mul_b   = '0;
    div_req = '{start: 1'b0, rem_init: '0, dividend: '0, divisor: '0, steps: '0};
    case (state_q)
      kti_pkg::S_IDLE: begin
        if (accept && n_act != 4'd0 &&
            (item_i.cmd == kti_pkg::CMD_RESET || item_i.cmd == kti_pkg::CMD_STEP ||
             item_i.cmd == kti_pkg::CMD_SEEK)) begin
          tc_d      = '0;
          rst_cmd_d = item_i.cmd == kti_pkg::CMD_RESET;
          seek_d    = item_i.cmd == kti_pkg::CMD_SEEK;
          step_d    = item_i.frame_step;
          state_d   = (item_i.cmd == kti_pkg::CMD_RESET) ? kti_pkg::S_RST : kti_pkg::S_LAST;
        end
      end
      kti_pkg::S_RST: begin
        raddr   = {tc_q, 4'd0};
        trk_we  = 1'b1;
        state_d = kti_pkg::S_RSTV;
      end
      kti_pkg::S_RSTV: begin
        val_d   = rdata.key_level;
        state_d = kti_pkg::S_OUT;
      end
      kti_pkg::S_LAST: begin
        raddr   = {tc_q, last};
        state_d = kti_pkg::S_DUR;
      end
      kti_pkg::S_DUR: begin
        dur_d   = rdata.key_time;
        pos_d   = {1'b0, base_pos} + {1'b0, step_q};
        seg_d   = seek_q ? 4'd0 : segment_q[tc_q];
        wrap_d  = 1'b0;
        state_d = kti_pkg::S_WALK;
      end
      kti_pkg::S_WALK: begin
        raddr = {tc_q, 4'(seg_q + 4'd1)};
        state_d = (seg_q < last) ? kti_pkg::S_WCMP : kti_pkg::S_END;
      end
      kti_pkg::S_WCMP: begin
        if (pos_q >= {1'b0, rdata.key_time}) begin
          seg_d   = seg_q + 4'd1;
          state_d = kti_pkg::S_WALK;
        end else begin
          state_d = kti_pkg::S_SAVE;
        end
      end
      kti_pkg::S_END: begin
        if (wrap_q) begin
          state_d = kti_pkg::S_SAVE;
        end else if (finish_q[tc_q] == kti_pkg::FINISH_HOLD || dur_q == 32'd0) begin
          seg_d   = last;
          pos_d   = {1'b0, dur_q};
          state_d = kti_pkg::S_SAVE;
        end else begin
          div_req = '{start: 1'b1, rem_init: '0, dividend: pos_q,
                      divisor: {2'b00, dur_q}, steps: 6'd33};
          state_d = kti_pkg::S_MOD;
        end
      end
      kti_pkg::S_MOD: begin
        if (!div_busy) begin
          pos_d   = div_rem[32:0];
          seg_d   = '0;
          wrap_d  = 1'b1;
          state_d = kti_pkg::S_WALK;
        end
      end
      kti_pkg::S_SAVE: begin
        trk_we = 1'b1;
        if (seg_q >= last) begin
          raddr   = {tc_q, last};
          state_d = kti_pkg::S_HOLDV;
        end else begin
          raddr   = {tc_q, seg_q};
          state_d = kti_pkg::S_KA;
        end
      end
      kti_pkg::S_HOLDV: begin
        val_d   = rdata.key_level;
        state_d = kti_pkg::S_OUT;
      end
      kti_pkg::S_KA: begin
        ta_d    = rdata.key_time;
        la_d    = rdata.key_level;
        ga_d    = rdata.key_gradient;
        delta_d = delta_c;
        mul_a   = delta_c;
        mul_b   = MW'(rdata.key_gradient);
        raddr   = {tc_q, 4'(seg_q + 4'd1)};
        if (rdata.curve == kti_pkg::CURVE_LINEAR) begin
          state_d = kti_pkg::S_LIN;
        end else if (rdata.curve == kti_pkg::CURVE_HERMITE) begin
          state_d = kti_pkg::S_KB;
        end else begin
          val_d   = rdata.key_level;
          state_d = kti_pkg::S_OUT;
        end
      end
      kti_pkg::S_LIN: begin
        val_d   = kti_pkg::sat32(lin_sum);
        state_d = kti_pkg::S_OUT;
      end
      kti_pkg::S_KB: begin
        lb_d   = rdata.key_level;
        gb_d   = rdata.key_gradient;
        span_d = (span_c < 0) ? '0 : span_c;
        if (delta_q <= 0 || span_c <= 0) begin
          tq_d    = '0;
          state_d = kti_pkg::S_M1;
        end else if (delta_q >= span_c) begin
          tq_d    = 16'hffff;
          state_d = kti_pkg::S_M1;
        end else begin
          div_req = '{start: 1'b1, rem_init: delta_q, dividend: '0,
                      divisor: span_c, steps: 6'd16};
          state_d = kti_pkg::S_TDIV;
        end
      end
      kti_pkg::S_TDIV: begin
        if (!div_busy) begin
          tq_d    = div_quot;
          state_d = kti_pkg::S_M1;
        end
      end
      kti_pkg::S_M1: begin
        mul_a   = $signed({18'd0, tq_q});
        mul_b   = $signed({18'd0, tq_q});
        state_d = kti_pkg::S_M2;
      end
      kti_pkg::S_M2: begin
        t2_d    = prod[31:16];
        mul_a   = $signed({18'd0, prod[31:16]});
        mul_b   = $signed({18'd0, tq_q});
        state_d = kti_pkg::S_M3;
      end
      kti_pkg::S_M3: begin
        t3_d    = prod[31:16];
        state_d = kti_pkg::S_M4;
      end
      kti_pkg::S_M4: begin
        mul_a   = MW'(h10);
        mul_b   = span_q;
        state_d = kti_pkg::S_M5;
      end
      kti_pkg::S_M5: begin
        s10_d   = prod_sh[MW-1:0];
        mul_a   = MW'(h11);
        mul_b   = span_q;
        state_d = kti_pkg::S_M6;
      end
      kti_pkg::S_M6: begin
        s11_d   = prod_sh[MW-1:0];
        mul_a   = MW'(h00);
        mul_b   = MW'(la_q);
        state_d = kti_pkg::S_M7;
      end
      kti_pkg::S_M7: begin
        acc_d   = prod[63:0];
        mul_a   = MW'(h01);
        mul_b   = MW'(lb_q);
        state_d = kti_pkg::S_M8;
      end
      kti_pkg::S_M8: begin
        acc_d   = acc_q + prod[63:0];
        mul_a   = s10_q;
        mul_b   = MW'(ga_q);
        state_d = kti_pkg::S_M9;
      end
      kti_pkg::S_M9: begin
        acc_d   = acc_q + prod_sh[63:0];
        mul_a   = s11_q;
        mul_b   = MW'(gb_q);
        state_d = kti_pkg::S_M10;
      end
      kti_pkg::S_M10: begin
        acc_d   = acc_q + prod_sh[63:0];
        state_d = kti_pkg::S_FIN;
      end
      kti_pkg::S_FIN: begin
        val_d   = kti_pkg::sat32(acc_q >>> 16);
        state_d = kti_pkg::S_OUT;
      end
      kti_pkg::S_OUT: begin
        valid_d = 1'b1;
        res_d   = '{out_track: tc_q, out_value: val_q, out_last: is_last_trk};
        if (is_last_trk) begin
          state_d = kti_pkg::S_IDLE;
        end else begin
          tc_d    = tc_q + 3'd1;
          state_d = rst_cmd_q ? kti_pkg::S_RST : kti_pkg::S_LAST;
        end
      end
      default: begin
        state_d = kti_pkg::S_IDLE;
      end
    endcase
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  `KTI_ASSERT(a_no_result_after_accept, accept |=> !res_valid_o, "result right after accept")
  `KTI_ASSERT(a_last_frees, (res_valid_o && res_o.out_last) |-> !busy, "busy after last result")
  `KTI_ASSERT(a_more_keeps_busy, (res_valid_o && !res_o.out_last) |-> busy, "idle before last")
  `KTI_NEVER(a_track_in_range, res_valid_o && ({1'b0, res_o.out_track} >= n_act), "bad track")

endmodule
